// ===== rtl/core/sorted_deadline_timer_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted deadline timer queue
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define SDTQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define SDTQ_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sdtq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted deadline timer queue package
// Shared defaults, operation and result codes, and control structs.
// ----------------------------------------------------------------------------
package sdtq_pkg;

  localparam int unsigned DefDepth    = 16;
  localparam int unsigned DefTimeBits = 32;
  localparam int unsigned DefTagBits  = 16;

  localparam int unsigned ActionW = 2;
  localparam int unsigned KindW   = 3;

  typedef enum logic [ActionW-1:0] {
    ACT_SCHEDULE = 2'd0,
    ACT_CANCEL   = 2'd1,
    ACT_PROCESS  = 2'd2,
    ACT_STATUS   = 2'd3
  } action_e;

  typedef enum logic [KindW-1:0] {
    KIND_SCHEDULED = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_MISS      = 3'd3,
    KIND_EXPIRED   = 3'd4,
    KIND_DONE      = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DISPATCH = 3'd1,
    ST_SCAN     = 3'd2,
    ST_COMPACT  = 3'd3,
    ST_PROC     = 3'd4
  } state_e;

  // Operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD    = 3'd0,
    OP_INSERT  = 3'd1,
    OP_KILL    = 3'd2,
    OP_COMPACT = 3'd3,
    OP_POP     = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     never;   // entry being inserted has an infinite deadline
  } cell_ctrl_t;

  // Head view of the chain
  typedef struct packed {
    logic head_occ;
    logic head_never;
    logic head_first;  // an insert would land at the head
    logic second_occ;
    logic second_never;
  } chain_stat_t;

endpackage

// ===== rtl/core/sdtq_in_if.sv =====
// ----------------------------------------------------------------------------
// Timer queue request channel
// Valid/ready channel carrying one request beat.
// ----------------------------------------------------------------------------
interface sdtq_in_if #(
  parameter int unsigned TIME_BITS = sdtq_pkg::DefTimeBits,
  parameter int unsigned TAG_BITS  = sdtq_pkg::DefTagBits,
  parameter int unsigned SLOT_BITS = $clog2(sdtq_pkg::DefDepth)
);
  logic                         valid;
  logic                         ready;
  logic [sdtq_pkg::ActionW-1:0] action;
  logic [TIME_BITS-1:0]         deadline_target;
  logic                         deadline_infinite;
  logic [TAG_BITS-1:0]          tag;
  logic [SLOT_BITS-1:0]         handle;
  logic [TIME_BITS-1:0]         now;

  modport source (
    output valid, action, deadline_target, deadline_infinite, tag, handle, now,
    input  ready
  );
  modport sink (
    input  valid, action, deadline_target, deadline_infinite, tag, handle, now,
    output ready
  );
endinterface

// ===== rtl/core/sdtq_out_if.sv =====
// ----------------------------------------------------------------------------
// Timer queue result channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface sdtq_out_if #(
  parameter int unsigned TIME_BITS = sdtq_pkg::DefTimeBits,
  parameter int unsigned TAG_BITS  = sdtq_pkg::DefTagBits,
  parameter int unsigned SLOT_BITS = $clog2(sdtq_pkg::DefDepth),
  parameter int unsigned CNT_BITS  = $clog2(sdtq_pkg::DefDepth + 1)
);
  logic                       valid;
  logic                       ready;
  logic [sdtq_pkg::KindW-1:0] kind;
  logic [SLOT_BITS-1:0]       slot;
  logic [TAG_BITS-1:0]        expired_tag;
  logic                       last;
  logic [CNT_BITS-1:0]        pending_count;
  logic                       head_present;
  logic [TIME_BITS-1:0]       next_target;
  logic                       next_infinite;

  modport source (
    output valid, kind, slot, expired_tag, last, pending_count, head_present,
           next_target, next_infinite,
    input  ready
  );
  modport sink (
    input  valid, kind, slot, expired_tag, last, pending_count, head_present,
           next_target, next_infinite,
    output ready
  );
endinterface

// ===== rtl/core/sdtq_cell.sv =====
// ----------------------------------------------------------------------------
// Timer queue cell
// One order position: holds an entry and trades it with its neighbors.
// ----------------------------------------------------------------------------
module sdtq_cell #(
  parameter int unsigned TIME_BITS = sdtq_pkg::DefTimeBits,
  parameter int unsigned TAG_BITS  = sdtq_pkg::DefTagBits,
  parameter int unsigned SLOT_BITS = $clog2(sdtq_pkg::DefDepth)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sdtq_pkg::cell_ctrl_t ctrl_i,
  input  logic [TIME_BITS-1:0] new_target_i,
  input  logic [TAG_BITS-1:0]  new_tag_i,
  input  logic [SLOT_BITS-1:0] new_slot_i,
  input  logic                 prev_first_i,
  input  logic                 prev_occ_i,
  input  logic                 prev_never_i,
  input  logic [TIME_BITS-1:0] prev_target_i,
  input  logic [TAG_BITS-1:0]  prev_tag_i,
  input  logic [SLOT_BITS-1:0] prev_slot_i,
  input  logic                 next_occ_i,
  input  logic                 next_never_i,
  input  logic [TIME_BITS-1:0] next_target_i,
  input  logic [TAG_BITS-1:0]  next_tag_i,
  input  logic [SLOT_BITS-1:0] next_slot_i,
  output logic                 first_o,
  output logic                 occ_o,
  output logic                 never_o,
  output logic [TIME_BITS-1:0] target_o,
  output logic [TAG_BITS-1:0]  tag_o,
  output logic [SLOT_BITS-1:0] slot_o
);

  logic                 occ_q, occ_d;
  logic                 never_q, never_d;
  logic [TIME_BITS-1:0] target_q, target_d;
  logic [TAG_BITS-1:0]  tag_q, tag_d;
  logic [SLOT_BITS-1:0] slot_q, slot_d;

  // New entry sorts before this one (ties stay behind)
  assign first_o = !occ_q ||
                   (!ctrl_i.never && (never_q || (new_target_i < target_q)));

  // Select next contents per broadcast operation
  always_comb begin
    occ_d    = occ_q;
    never_d  = never_q;
    target_d = target_q;
    tag_d    = tag_q;
    slot_d   = slot_q;
    unique case (ctrl_i.op)
      sdtq_pkg::OP_INSERT: begin
        if (prev_first_i) begin
          occ_d    = prev_occ_i;
          never_d  = prev_never_i;
          target_d = prev_target_i;
          tag_d    = prev_tag_i;
          slot_d   = prev_slot_i;
        end else if (first_o) begin
          occ_d    = 1'b1;
          never_d  = ctrl_i.never;
          target_d = new_target_i;
          tag_d    = new_tag_i;
          slot_d   = new_slot_i;
        end
      end
      sdtq_pkg::OP_KILL: begin
        if (occ_q && (slot_q == new_slot_i)) begin
          occ_d = 1'b0;
        end
      end
      sdtq_pkg::OP_COMPACT: begin
        if (!occ_q) begin
          occ_d    = next_occ_i;
          never_d  = next_never_i;
          target_d = next_target_i;
          tag_d    = next_tag_i;
          slot_d   = next_slot_i;
        end else if (!prev_occ_i) begin
          occ_d = 1'b0;
        end
      end
      sdtq_pkg::OP_POP: begin
        occ_d    = next_occ_i;
        never_d  = next_never_i;
        target_d = next_target_i;
        tag_d    = next_tag_i;
        slot_d   = next_slot_i;
      end
      default: begin
        occ_d = occ_q;
      end
    endcase
  end

  // Occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Entry payload
  always_ff @(posedge clk_i) begin
    never_q  <= never_d;
    target_q <= target_d;
    tag_q    <= tag_d;
    slot_q   <= slot_d;
  end

  assign occ_o    = occ_q;
  assign never_o  = never_q;
  assign target_o = target_q;
  assign tag_o    = tag_q;
  assign slot_o   = slot_q;

endmodule

// ===== rtl/core/sdtq_chain.sv =====
// ----------------------------------------------------------------------------
// Timer queue cell chain
// Row of cells kept in deadline order, head at position zero.
// ----------------------------------------------------------------------------
module sdtq_chain #(
  parameter int unsigned DEPTH     = sdtq_pkg::DefDepth,
  parameter int unsigned TIME_BITS = sdtq_pkg::DefTimeBits,
  parameter int unsigned TAG_BITS  = sdtq_pkg::DefTagBits,
  parameter int unsigned SLOT_BITS = $clog2(sdtq_pkg::DefDepth)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sdtq_pkg::cell_ctrl_t  ctrl_i,
  input  logic [TIME_BITS-1:0]  new_target_i,
  input  logic [TAG_BITS-1:0]   new_tag_i,
  input  logic [SLOT_BITS-1:0]  new_slot_i,
  output sdtq_pkg::chain_stat_t stat_o,
  output logic [TIME_BITS-1:0]  head_target_o,
  output logic [TAG_BITS-1:0]   head_tag_o,
  output logic [SLOT_BITS-1:0]  head_slot_o,
  output logic [TIME_BITS-1:0]  second_target_o
);

  // Index 0 and DEPTH+1 are boundary ties; cell i sits at index i+1
  logic                 first_w  [DEPTH+2];
  logic                 occ_w    [DEPTH+2];
  logic                 never_w  [DEPTH+2];
  logic [TIME_BITS-1:0] target_w [DEPTH+2];
  logic [TAG_BITS-1:0]  tag_w    [DEPTH+2];
  logic [SLOT_BITS-1:0] slot_w   [DEPTH+2];

  // Tie the front: nothing sorts ahead of the head, and it never looks empty
  assign first_w[0]  = 1'b0;
  assign occ_w[0]    = 1'b1;
  assign never_w[0]  = 1'b0;
  assign target_w[0] = '0;
  assign tag_w[0]    = '0;
  assign slot_w[0]   = '0;

  // Tie the tail: empty entry shifts in
  assign first_w[DEPTH+1]  = 1'b1;
  assign occ_w[DEPTH+1]    = 1'b0;
  assign never_w[DEPTH+1]  = 1'b0;
  assign target_w[DEPTH+1] = '0;
  assign tag_w[DEPTH+1]    = '0;
  assign slot_w[DEPTH+1]   = '0;

  for (genvar i = 1; i <= DEPTH; i++) begin : g_cell
    sdtq_cell #(
      .TIME_BITS (TIME_BITS),
      .TAG_BITS  (TAG_BITS),
      .SLOT_BITS (SLOT_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl_i),
      .new_target_i  (new_target_i),
      .new_tag_i     (new_tag_i),
      .new_slot_i    (new_slot_i),
      .prev_first_i  (first_w[i-1]),
      .prev_occ_i    (occ_w[i-1]),
      .prev_never_i  (never_w[i-1]),
      .prev_target_i (target_w[i-1]),
      .prev_tag_i    (tag_w[i-1]),
      .prev_slot_i   (slot_w[i-1]),
      .next_occ_i    (occ_w[i+1]),
      .next_never_i  (never_w[i+1]),
      .next_target_i (target_w[i+1]),
      .next_tag_i    (tag_w[i+1]),
      .next_slot_i   (slot_w[i+1]),
      .first_o       (first_w[i]),
      .occ_o         (occ_w[i]),
      .never_o       (never_w[i]),
      .target_o      (target_w[i]),
      .tag_o         (tag_w[i]),
      .slot_o        (slot_w[i])
    );
  end

  // Expose the two front positions
  assign stat_o.head_occ     = occ_w[1];
  assign stat_o.head_never   = never_w[1];
  assign stat_o.head_first   = first_w[1];
  assign stat_o.second_occ   = occ_w[2];
  assign stat_o.second_never = never_w[2];
  assign head_target_o       = target_w[1];
  assign head_tag_o          = tag_w[1];
  assign head_slot_o         = slot_w[1];
  assign second_target_o     = target_w[2];

endmodule

// ===== rtl/core/sorted_deadline_timer_queue.sv =====
// Status, full and cancel miss: the request beat is registered, then dispatch registers the result beat.
// Schedule: the slot bitmap is scanned one slot a cycle for the lowest free slot, then the entry is inserted.
// Cancel: the entry is killed, then the hole bubbles one cell a cycle through the chain.
// Process: one head pop a cycle per expired entry, while the result register is free.
// One request at a time; a new request is taken after the last result is registered.
// Reset: asynchronous; clears control, occupancy and slot bitmap, no clearing pass.
// ----------------------------------------------------------------------------
// Sorted deadline timer queue
// Timer entries kept in deadline order in a chain of cells, with a slot
// bitmap for handles and a sequencer that issues one chain operation a cycle.
// ----------------------------------------------------------------------------
`include "sorted_deadline_timer_queue_macros.svh"

module sorted_deadline_timer_queue #(
  parameter int unsigned DEPTH     = sdtq_pkg::DefDepth,
  parameter int unsigned TIME_BITS = sdtq_pkg::DefTimeBits,
  parameter int unsigned TAG_BITS  = sdtq_pkg::DefTagBits
) (
  input logic      clk_i,
  input logic      rst_ni,
  sdtq_in_if.sink  in_i,
  sdtq_out_if.source out_o
);

  localparam int unsigned SlotW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned PadW  = 2 ** SlotW;
  localparam logic [SlotW-1:0] StepLast = SlotW'(DEPTH - 1);

  sdtq_pkg::state_e  state_q, state_d;
  sdtq_pkg::action_e action_q;
  logic [TIME_BITS-1:0] target_q;
  logic                 inf_q;
  logic [TAG_BITS-1:0]  tag_q;
  logic [SlotW-1:0]     handle_q;
  logic [TIME_BITS-1:0] now_q;

  logic [DEPTH-1:0] slot_valid_q, slot_valid_d;
  logic [PadW-1:0]  valid_pad;
  logic [CntW-1:0]  count_q, count_d;
  logic [SlotW-1:0] scan_q, scan_d;
  logic [SlotW-1:0] step_q, step_d;

  sdtq_pkg::cell_ctrl_t  ctrl;
  sdtq_pkg::chain_stat_t stat;
  logic [TIME_BITS-1:0]  head_target;
  logic [TAG_BITS-1:0]   head_tag;
  logic [SlotW-1:0]      head_slot;
  logic [TIME_BITS-1:0]  second_target;
  logic [SlotW-1:0]      chain_slot;

  logic in_accept, out_free, hit, expire;

  logic                 emit;
  sdtq_pkg::kind_e      e_kind;
  logic [SlotW-1:0]     e_slot;
  logic [TAG_BITS-1:0]  e_tag;
  logic                 e_last;
  logic [CntW-1:0]      e_cnt;
  logic                 e_has;
  logic [TIME_BITS-1:0] e_tgt;
  logic                 e_inf;

  logic                 out_valid_q;
  sdtq_pkg::kind_e      kind_q;
  logic [SlotW-1:0]     slot_q;
  logic [TAG_BITS-1:0]  etag_q;
  logic                 last_q;
  logic [CntW-1:0]      cnt_q;
  logic                 has_q;
  logic [TIME_BITS-1:0] ntgt_q;
  logic                 ninf_q;

  assign in_accept = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign valid_pad = PadW'(slot_valid_q);
  assign hit       = (CntW'(handle_q) < CntW'(DEPTH)) && valid_pad[handle_q];
  assign expire    = stat.head_occ && !stat.head_never && (head_target <= now_q);
  // Cancel matches on the handle, insert writes the scanned slot
  assign chain_slot = (state_q == sdtq_pkg::ST_SCAN) ? scan_q : handle_q;

  sdtq_chain #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS),
    .TAG_BITS  (TAG_BITS),
    .SLOT_BITS (SlotW)
  ) u_chain (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .new_target_i    (target_q),
    .new_tag_i       (tag_q),
    .new_slot_i      (chain_slot),
    .stat_o          (stat),
    .head_target_o   (head_target),
    .head_tag_o      (head_tag),
    .head_slot_o     (head_slot),
    .second_target_o (second_target)
  );

  // Sequence one chain operation per cycle and build result beats
  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    step_d       = step_q;
    count_d      = count_q;
    slot_valid_d = slot_valid_q;
    ctrl.op      = sdtq_pkg::OP_HOLD;
    ctrl.never   = inf_q;
    in_i.ready   = 1'b0;
    emit         = 1'b0;
    e_kind       = sdtq_pkg::KIND_DONE;
    e_slot       = '0;
    e_tag        = '0;
    e_last       = 1'b1;
    e_cnt        = count_q;
    e_has        = stat.head_occ;
    e_tgt        = stat.head_occ ? head_target : '0;
    e_inf        = stat.head_occ && stat.head_never;
    unique case (state_q)
      sdtq_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = sdtq_pkg::ST_DISPATCH;
        end
      end
      sdtq_pkg::ST_DISPATCH: begin
        unique case (action_q)
          sdtq_pkg::ACT_SCHEDULE: begin
            if (count_q == CntW'(DEPTH)) begin
              if (out_free) begin
                emit    = 1'b1;
                e_kind  = sdtq_pkg::KIND_FULL;
                state_d = sdtq_pkg::ST_IDLE;
              end
            end else begin
              scan_d  = '0;
              state_d = sdtq_pkg::ST_SCAN;
            end
          end
          sdtq_pkg::ACT_CANCEL: begin
            if (hit) begin
              ctrl.op                = sdtq_pkg::OP_KILL;
              slot_valid_d[handle_q] = 1'b0;
              count_d                = count_q - CntW'(1);
              step_d                 = '0;
              state_d                = sdtq_pkg::ST_COMPACT;
            end else if (out_free) begin
              emit    = 1'b1;
              e_kind  = sdtq_pkg::KIND_MISS;
              e_slot  = handle_q;
              state_d = sdtq_pkg::ST_IDLE;
            end
          end
          sdtq_pkg::ACT_PROCESS: begin
            state_d = sdtq_pkg::ST_PROC;
          end
          default: begin
            if (out_free) begin
              emit    = 1'b1;
              state_d = sdtq_pkg::ST_IDLE;
            end
          end
        endcase
      end
      sdtq_pkg::ST_SCAN: begin
        if (!valid_pad[scan_q]) begin
          if (out_free) begin
            ctrl.op              = sdtq_pkg::OP_INSERT;
            slot_valid_d[scan_q] = 1'b1;
            count_d              = count_q + CntW'(1);
            emit                 = 1'b1;
            e_kind               = sdtq_pkg::KIND_SCHEDULED;
            e_slot               = scan_q;
            e_cnt                = count_q + CntW'(1);
            e_has                = 1'b1;
            if (stat.head_first) begin
              e_tgt = target_q;
              e_inf = inf_q;
            end
            state_d = sdtq_pkg::ST_IDLE;
          end
        end else begin
          scan_d = scan_q + SlotW'(1);
        end
      end
      sdtq_pkg::ST_COMPACT: begin
        ctrl.op = sdtq_pkg::OP_COMPACT;
        if (step_q == StepLast) begin
          if (out_free) begin
            emit    = 1'b1;
            e_kind  = sdtq_pkg::KIND_CANCELLED;
            e_slot  = handle_q;
            state_d = sdtq_pkg::ST_IDLE;
          end
        end else begin
          step_d = step_q + SlotW'(1);
        end
      end
      sdtq_pkg::ST_PROC: begin
        if (out_free) begin
          emit = 1'b1;
          if (expire) begin
            ctrl.op                 = sdtq_pkg::OP_POP;
            slot_valid_d[head_slot] = 1'b0;
            count_d                 = count_q - CntW'(1);
            e_kind                  = sdtq_pkg::KIND_EXPIRED;
            e_slot                  = head_slot;
            e_tag                   = head_tag;
            e_last                  = 1'b0;
            e_cnt                   = count_q - CntW'(1);
            e_has                   = stat.second_occ;
            e_tgt                   = stat.second_occ ? second_target : '0;
            e_inf                   = stat.second_occ && stat.second_never;
          end else begin
            state_d = sdtq_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = sdtq_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sdtq_pkg::ST_IDLE;
      slot_valid_q <= '0;
      count_q      <= '0;
      scan_q       <= '0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_valid_q <= slot_valid_d;
      count_q      <= count_d;
      scan_q       <= scan_d;
      step_q       <= step_d;
      out_valid_q  <= emit || (out_valid_q && !out_o.ready);
    end
  end

  // Capture the request beat
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      action_q <= sdtq_pkg::action_e'(in_i.action);
      target_q <= in_i.deadline_target;
      inf_q    <= in_i.deadline_infinite;
      tag_q    <= in_i.tag;
      handle_q <= in_i.handle;
      now_q    <= in_i.now;
    end
  end

  // Result beat register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= e_kind;
      slot_q <= e_slot;
      etag_q <= e_tag;
      last_q <= e_last;
      cnt_q  <= e_cnt;
      has_q  <= e_has;
      ntgt_q <= e_tgt;
      ninf_q <= e_inf;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = kind_q;
  assign out_o.slot          = slot_q;
  assign out_o.expired_tag   = etag_q;
  assign out_o.last          = last_q;
  assign out_o.pending_count = cnt_q;
  assign out_o.head_present  = has_q;
  assign out_o.next_target   = ntgt_q;
  assign out_o.next_infinite = ninf_q;

  // Queue length stays within capacity and matches the slot bitmap
  `SDTQ_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CntW'(DEPTH), "count above capacity")
  `SDTQ_ASSERT(a_count_bitmap, clk_i, rst_ni, $countones(slot_valid_q) == int'(count_q), "count differs from slot bitmap")
  // Outside compaction the chain head is occupied exactly when entries are queued
  `SDTQ_IMPLY(a_head_occ, clk_i, rst_ni, state_q != sdtq_pkg::ST_COMPACT, stat.head_occ == (count_q != '0), "chain head disagrees with count")
  // Only expiry beats may be followed by more beats of the same request
  `SDTQ_IMPLY(a_last_beat, clk_i, rst_ni, out_valid_q && (kind_q != sdtq_pkg::KIND_EXPIRED), last_q, "non-expiry beat without last")

endmodule
